@@ src/md5_pkg.sv @@
// Package: MD5 state type, constants and round functions.
`timescale 1ns / 1ps

package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [2:0]  MAX_BYTES   = 3'd4;
    localparam logic [3:0]  LEN_LO_WORD = 4'd14;
    localparam logic [3:0]  LEN_HI_WORD = 4'd15;
    localparam logic [5:0]  LAST_ROUND  = 6'd63;
    localparam logic [1:0]  LAST_INDEX  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,   // take input items
        S_PRE,    // first message word read in flight
        S_RND,    // one round per cycle
        S_FIN,    // add working words into chaining value
        S_PAD,    // write word holding the 0x80 marker
        S_ZERO,   // zero-fill up to the length words, or to block end on pad spill
        S_LEN_LO,
        S_LEN_HI,
        S_DONE    // hand digest to output register
    } t_state;

    // Message word index for round r.
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] g;
        begin
            unique case (r[5:4])
                2'd0: g = r[3:0];
                2'd1: g = 4'(5 * r[3:0] + 1);
                2'd2: g = 4'(3 * r[3:0] + 5);
                2'd3: g = 4'(7 * r[3:0]);
                default: g = r[3:0];
            endcase
            return g;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        begin
            unique case ({r[5:4], r[1:0]})
                4'd0:  s = 5'd7;
                4'd1:  s = 5'd12;
                4'd2:  s = 5'd17;
                4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;
                4'd5:  s = 5'd9;
                4'd6:  s = 5'd14;
                4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;
                4'd9:  s = 5'd11;
                4'd10: s = 5'd16;
                4'd11: s = 5'd23;
                4'd12: s = 5'd6;
                4'd13: s = 5'd10;
                4'd14: s = 5'd15;
                4'd15: s = 5'd21;
                default: s = 5'd7;
            endcase
            return s;
        end
    endfunction

    function automatic logic [31:0] round_fn(input logic [1:0] phase,
                                             input logic [31:0] b,
                                             input logic [31:0] c,
                                             input logic [31:0] d);
        logic [31:0] f;
        begin
            unique case (phase)
                2'd0: f = (b & c) | (~b & d);
                2'd1: f = (d & b) | (~d & c);
                2'd2: f = b ^ c ^ d;
                2'd3: f = c ^ (b | ~d);
                default: f = b ^ c ^ d;
            endcase
            return f;
        end
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        begin
            w = {x, x} << n;
            return w[63:32];
        end
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

endpackage

@@ src/md5_message_digest_unit.sv @@
// Top level: MD5 digest engine with block buffer memory and one round per cycle.
`timescale 1ns / 1ps
// Input: one item per cycle while idle; the item that completes a 64-byte block
//   starts compression (read setup, 64 rounds, chaining add) and input waits.
// A last item is followed by the pad word, zero-fill and two length writes, then
//   compression (twice when it fills the block or the pad spills over), the digest
//   handoff to the output register, then 4 output words.
// Reset (sync, active low): initial chaining words, length/fill/control cleared;
//   the buffer memory is not cleared (never read before write).

module md5_message_digest_unit
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] byte_count, rest 0
    input  logic        s_axis_tlast,   // last
    // digest stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);

    t_state r_state, n_state;

    // block buffer: 16 words, sync write, registered read
    logic [31:0] r_mem [16];
    logic [31:0] r_rd_data;
    logic        mem_we;
    logic [3:0]  mem_wa;
    logic [31:0] mem_wd;
    logic [3:0]  mem_ra;

    // message state
    logic [31:0] r_cv_a, r_cv_b, r_cv_c, r_cv_d;
    logic [63:0] r_bitlen;
    logic [5:0]  r_fill;
    logic [31:0] r_part;        // partially filled word, unused bytes zero
    logic        r_last;        // padding still owed for this message
    logic        r_need;        // pad spills past word 13: extra block first
    logic        r_final;       // compression in flight is the length block
    logic [4:0]  r_widx;        // zero-fill pointer, may reach 16

    // round unit
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_round;

    // output register
    logic [127:0] r_dig;
    logic         r_ovalid;
    logic [1:0]   r_oidx;

    logic s_hs, m_hs;
    assign s_hs = s_axis_tvalid & s_axis_tready;
    assign m_hs = m_axis_tvalid & m_axis_tready;

    // --- input byte merge -------------------------------------------------
    logic [2:0]  in_cnt;
    logic [31:0] in_masked;
    logic [63:0] merged;
    logic [3:0]  byte_total;
    logic        word_done;
    logic        block_full;

    always_comb begin
        in_cnt = (s_axis_tdata[34:32] > MAX_BYTES) ? MAX_BYTES : s_axis_tdata[34:32];
        for (int i = 0; i < 4; i++) begin
            in_masked[8*i +: 8] = (3'(i) < in_cnt) ? s_axis_tdata[8*i +: 8] : 8'h00;
        end
        merged     = {32'h0, r_part} | ({32'h0, in_masked} << {r_fill[1:0], 3'b000});
        byte_total = {2'b00, r_fill[1:0]} + {1'b0, in_cnt};
        word_done  = byte_total[2];     // total of 4..7 bytes closes a word
        block_full = word_done && (r_fill[5:2] == 4'hf);
    end

    // --- round datapath ---------------------------------------------------
    logic [31:0] rnd_sum, rnd_b;
    always_comb begin
        rnd_sum = r_a + round_fn(r_round[5:4], r_b, r_c, r_d) + round_const(r_round)
                  + r_rd_data;
        rnd_b   = r_b + rotl32(rnd_sum, rot_amount(r_round));
    end

    logic [4:0] zero_limit;
    assign zero_limit = r_need ? 5'd16 : {1'b0, LEN_LO_WORD};

    // --- control ----------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_wa        = r_fill[5:2];
        mem_wd        = merged[31:0];
        mem_ra        = msg_index(6'(r_round + 6'd1));
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_hs) begin
                    mem_we = word_done;
                    if (block_full) begin
                        n_state = S_PRE;
                    end else if (s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PRE: begin
                mem_ra  = msg_index(6'd0);
                n_state = S_RND;
            end
            S_RND: begin
                if (r_round == LAST_ROUND) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                priority if (r_final) begin
                    n_state = S_DONE;
                end else if (r_need) begin
                    n_state = S_ZERO;
                end else if (r_last) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                mem_we  = 1'b1;
                mem_wd  = r_part | ({24'h0, PAD_BYTE} << {r_fill[1:0], 3'b000});
                n_state = S_ZERO;
            end
            S_ZERO: begin
                if (r_widx == zero_limit) begin
                    n_state = r_need ? S_PRE : S_LEN_LO;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_widx[3:0];
                    mem_wd = 32'h0;
                end
            end
            S_LEN_LO: begin
                mem_we  = 1'b1;
                mem_wa  = LEN_LO_WORD;
                mem_wd  = r_bitlen[31:0];
                n_state = S_LEN_HI;
            end
            S_LEN_HI: begin
                mem_we  = 1'b1;
                mem_wa  = LEN_HI_WORD;
                mem_wd  = r_bitlen[63:32];
                n_state = S_PRE;
            end
            S_DONE: begin
                if (!r_ovalid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // --- block buffer memory ----------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // --- message and chaining state ---------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_a   <= INIT_A;
            r_cv_b   <= INIT_B;
            r_cv_c   <= INIT_C;
            r_cv_d   <= INIT_D;
            r_bitlen <= 64'h0;
            r_fill   <= 6'h0;
            r_part   <= 32'h0;
            r_last   <= 1'b0;
            r_need   <= 1'b0;
            r_final  <= 1'b0;
            r_widx   <= 5'h0;
            r_round  <= 6'h0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_hs) begin
                        r_part   <= word_done ? merged[63:32] : merged[31:0];
                        r_fill   <= r_fill + {3'b000, in_cnt};
                        r_bitlen <= r_bitlen + {58'h0, in_cnt, 3'b000};
                        r_last   <= s_axis_tlast;
                    end
                end
                S_PRE: begin
                    r_round <= 6'h0;
                end
                S_RND: begin
                    r_round <= r_round + 6'd1;
                end
                S_FIN: begin
                    r_cv_a <= r_cv_a + r_a;
                    r_cv_b <= r_cv_b + r_b;
                    r_cv_c <= r_cv_c + r_c;
                    r_cv_d <= r_cv_d + r_d;
                    if (!r_final && r_need) begin
                        r_need <= 1'b0;
                        r_widx <= 5'h0;
                    end
                end
                S_PAD: begin
                    r_widx <= {1'b0, r_fill[5:2]} + 5'd1;
                    r_need <= (r_fill[5:3] == 3'b111);  // marker lands in word 14 or 15
                    r_last <= 1'b0;
                end
                S_ZERO: begin
                    if (r_widx != zero_limit) begin
                        r_widx <= r_widx + 5'd1;
                    end
                end
                S_LEN_LO: begin
                end
                S_LEN_HI: begin
                    r_final <= 1'b1;
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_cv_a   <= INIT_A;
                        r_cv_b   <= INIT_B;
                        r_cv_c   <= INIT_C;
                        r_cv_d   <= INIT_D;
                        r_bitlen <= 64'h0;
                        r_fill   <= 6'h0;
                        r_part   <= 32'h0;
                        r_final  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working words: payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_PRE) begin
            r_a <= r_cv_a;
            r_b <= r_cv_b;
            r_c <= r_cv_c;
            r_d <= r_cv_d;
        end else if (r_state == S_RND) begin
            r_a <= r_d;
            r_b <= rnd_b;
            r_c <= r_b;
            r_d <= r_c;
        end
    end

    // --- output register: lets the next message start while words drain ---
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && !r_ovalid) begin
            r_dig <= {r_cv_d, r_cv_c, r_cv_b, r_cv_a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_oidx   <= 2'd0;
        end else if (r_state == S_DONE && !r_ovalid) begin
            r_ovalid <= 1'b1;
            r_oidx   <= 2'd0;
        end else if (m_hs) begin
            r_oidx <= r_oidx + 2'd1;
            if (r_oidx == LAST_INDEX) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_dig[{r_oidx, 5'b00000} +: 32];
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == LAST_INDEX);

    // --- assertions ---------------------------------------------------------
    a_no_write_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !(r_state == S_RND || r_state == S_PRE))
        else $error("buffer written while compression reads it");

    a_fin_after_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> ($past(r_state) == S_RND && $past(r_round) == LAST_ROUND))
        else $error("chaining add without 64 rounds");

    a_digest_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_hs && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("digest output not released after fourth word");

endmodule
